>>> design/iibf_pkg.sv
// Shared constants, types and codes of the integral image box filter.
package iibf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int CHANNELS   = 4;

  // Field and register widths.
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 9;
  localparam int QRY_W   = 8;
  localparam int NUM_CFG = 4;
  localparam int IDX_W   = 2;
  localparam int OUT_CH  = 4;

  // Coordinates and sizes.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = COL_W + 1;
  localparam int DIMY_W = ROW_W + 1;
  localparam int AREA_W = DIM_W + DIMY_W;
  localparam int ADDR_W = ROW_W + COL_W;

  // Summed-area arithmetic.
  localparam int SUM_W = 24;
  localparam int RUN_W = 16;
  localparam int REM_W = AREA_W + 1;
  localparam int CNT_W = $clog2(SUM_W + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_KERNEL_WIDTH  = 2'd2;
  localparam logic [IDX_W-1:0] REG_KERNEL_HEIGHT = 2'd3;

  // Request function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [CHANNELS-1:0][SUM_W-1:0] sat_word_t;

  // One classified request passed from front to back.
  typedef struct packed {
    logic                            is_query;
    logic [ROW_W-1:0]                row;
    logic [COL_W-1:0]                col;
    logic                            first_col;
    logic [CHANNELS-1:0][PIX_W-1:0]  pix;
    logic [DIM_W-1:0]                x1;
    logic [DIM_W-1:0]                x2;
    logic [DIMY_W-1:0]               y1;
    logic [DIMY_W-1:0]               y2;
    logic [AREA_W-1:0]               area;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LD_RD,
    B_LD_WR,
    B_Q_RD,
    B_Q_LAST,
    B_DIV,
    B_DONE
  } back_state_e;

endpackage

>>> design/iibf_front.sv
// Front end: configuration registers, load position tracking and request classification.
module iibf_front
  import iibf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 accept_i,
  input  logic                 func_i,
  input  logic [PIX_W-1:0]     chan0_i,
  input  logic [PIX_W-1:0]     chan1_i,
  input  logic [PIX_W-1:0]     chan2_i,
  input  logic [PIX_W-1:0]     chan3_i,
  input  logic [QRY_W-1:0]     query_x_i,
  input  logic [QRY_W-1:0]     query_y_i,
  output cmd_t                 cmd_o
);

  logic [CFG_W-1:0] img_w_q, img_h_q, ker_w_q, ker_h_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [DIM_W-1:0]  w_eff;
  logic [DIMY_W-1:0] h_eff;
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [DIM_W-1:0]  col_inc;
  logic [DIMY_W-1:0] row_inc;
  logic [DIM_W-1:0]  qx, hk, x1, x2;
  logic [DIMY_W-1:0] qy, vk, y1, y2;
  logic [DIM_W:0]    x2_raw;
  logic [DIMY_W:0]   y2_raw;
  logic [PIX_W-1:0]  chans [OUT_CH];

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= CFG_W'(256);
      img_h_q <= CFG_W'(256);
      ker_w_q <= CFG_W'(3);
      ker_h_q <= CFG_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:   img_w_q <= cfg_data_i;
        REG_IMAGE_HEIGHT:  img_h_q <= cfg_data_i;
        REG_KERNEL_WIDTH:  ker_w_q <= cfg_data_i;
        REG_KERNEL_HEIGHT: ker_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp image size to the supported range
  always_comb begin
    if (img_w_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(img_w_q) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(img_w_q);
    end
    if (img_h_q == '0) begin
      h_eff = DIMY_W'(1);
    end else if (32'(img_h_q) > MAX_HEIGHT) begin
      h_eff = DIMY_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIMY_W'(img_h_q);
    end
  end

  // Advance load position, restarting when it lies outside the image
  always_comb begin
    if (DIM_W'(col_q) >= w_eff || DIMY_W'(row_q) >= h_eff) begin
      col_cur = '0;
      row_cur = '0;
    end else begin
      col_cur = col_q;
      row_cur = row_q;
    end
    col_inc = DIM_W'(col_cur) + DIM_W'(1);
    row_inc = DIMY_W'(row_cur) + DIMY_W'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept_i && func_i == FUNC_LOAD) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[COL_W-1:0];
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Clip the query window to the image
  always_comb begin
    hk = DIM_W'(ker_w_q[CFG_W-1:1]);
    vk = DIMY_W'(ker_h_q[CFG_W-1:1]);
    qx = (DIM_W'(query_x_i) > w_eff - DIM_W'(1)) ? w_eff - DIM_W'(1) : DIM_W'(query_x_i);
    qy = (DIMY_W'(query_y_i) > h_eff - DIMY_W'(1)) ? h_eff - DIMY_W'(1)
                                                    : DIMY_W'(query_y_i);
    x1 = (qx >= hk) ? qx - hk : '0;
    y1 = (qy >= vk) ? qy - vk : '0;
    x2_raw = (DIM_W+1)'(qx) + (DIM_W+1)'(hk) + (DIM_W+1)'(1);
    y2_raw = (DIMY_W+1)'(qy) + (DIMY_W+1)'(vk) + (DIMY_W+1)'(1);
    x2 = (x2_raw > (DIM_W+1)'(w_eff)) ? w_eff : x2_raw[DIM_W-1:0];
    y2 = (y2_raw > (DIMY_W+1)'(h_eff)) ? h_eff : y2_raw[DIMY_W-1:0];
  end

  assign chans[0] = chan0_i;
  assign chans[1] = chan1_i;
  assign chans[2] = chan2_i;
  assign chans[3] = chan3_i;

  // Build the request for the back end
  always_comb begin
    cmd_o.is_query  = (func_i == FUNC_QUERY);
    cmd_o.row       = row_cur;
    cmd_o.col       = col_cur;
    cmd_o.first_col = (col_cur == '0);
    for (int c = 0; c < CHANNELS; c++) begin
      cmd_o.pix[c] = chans[c];
    end
    cmd_o.x1   = x1;
    cmd_o.x2   = x2;
    cmd_o.y1   = y1;
    cmd_o.y2   = y2;
    cmd_o.area = AREA_W'(x2 - x1) * AREA_W'(y2 - y1);
  end

endmodule

>>> design/iibf_fifo.sv
// Short request queue between front and back end.
module iibf_fifo
  import iibf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  cmd_t  wdata_i,
  output logic  full_o,
  input  logic  rd_i,
  output cmd_t  rdata_o,
  output logic  empty_o
);

  cmd_t              mem_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wptr_q, rptr_q;
  logic [FCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == FCNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Store a request
  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i && !full_o) begin
        wptr_q <= (32'(wptr_q) == FIFO_DEPTH - 1) ? '0 : wptr_q + FPTR_W'(1);
      end
      if (rd_i && !empty_o) begin
        rptr_q <= (32'(rptr_q) == FIFO_DEPTH - 1) ? '0 : rptr_q + FPTR_W'(1);
      end
      cnt_q <= cnt_q + FCNT_W'(wr_i && !full_o) - FCNT_W'(rd_i && !empty_o);
    end
  end

endmodule

>>> design/iibf_back.sv
// Back end: summed-area memory, load updates, corner reads and window division.
module iibf_back
  import iibf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_empty_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  input  logic              pop,
  output logic              empty,
  output logic [PIX_W-1:0]  mean0_o,
  output logic [PIX_W-1:0]  mean1_o,
  output logic [PIX_W-1:0]  mean2_o,
  output logic [PIX_W-1:0]  mean3_o
);

  back_state_e state_q, state_d;
  cmd_t        cmd_q;

  sat_word_t   mem [2**ADDR_W];
  sat_word_t   rd_q;
  logic        rd_zero_q, rd_zero_d;
  logic        rd_neg_q;
  logic        pend_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic        mem_re, mem_we;
  sat_word_t   wr_data;

  logic [1:0]  k_q, k_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CHANNELS-1:0][RUN_W-1:0] run_q, run_d;
  logic [CHANNELS-1:0][SUM_W-1:0] acc_q, acc_d;
  logic [CHANNELS-1:0][REM_W-1:0] rem_q, rem_d;
  logic [CHANNELS-1:0][SUM_W-1:0] dvd_q, dvd_d;
  logic [OUT_CH-1:0][PIX_W-1:0]   out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;

  logic [DIM_W-1:0]  cx;
  logic [DIMY_W-1:0] cy;
  logic [REM_W-1:0]  rem_sh;

  // Hold and issue memory accesses
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Select the corner for the current read: each of the four window corners in turn
  always_comb begin
    cy = k_q[0] ? cmd_q.y1 : cmd_q.y2;
    cx = k_q[1] ? cmd_q.x1 : cmd_q.x2;
  end

  // Next state, memory control and datapath
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    run_d     = run_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    out_d     = out_q;
    out_load  = 1'b0;
    cmd_pop_o = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = '0;
    wr_addr   = {cmd_q.row, cmd_q.col};
    wr_data   = '0;
    rd_zero_d = 1'b1;
    rem_sh    = '0;

    // Fold the corner that arrived last cycle into the window sum
    if (pend_q) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (!rd_zero_q) begin
          acc_d[c] = rd_neg_q ? acc_q[c] - rd_q[c] : acc_q[c] + rd_q[c];
        end
      end
    end

    case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          k_d       = '0;
          acc_d     = '0;
          state_d   = cmd_i.is_query ? B_Q_RD : B_LD_RD;
        end
      end
      B_LD_RD: begin
        mem_re    = 1'b1;
        rd_addr   = {cmd_q.row - ROW_W'(1), cmd_q.col};
        rd_zero_d = (cmd_q.row == '0);
        state_d   = B_LD_WR;
      end
      B_LD_WR: begin
        mem_we = 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
          run_d[c]   = (cmd_q.first_col ? '0 : run_q[c]) + RUN_W'(cmd_q.pix[c]);
          wr_data[c] = (rd_zero_q ? '0 : rd_q[c]) + SUM_W'(run_d[c]);
        end
        state_d = B_IDLE;
      end
      B_Q_RD: begin
        mem_re    = 1'b1;
        rd_addr   = {ROW_W'(cy - DIMY_W'(1)), COL_W'(cx - DIM_W'(1))};
        rd_zero_d = (cy == '0) || (cx == '0);
        k_d       = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = B_Q_LAST;
        end
      end
      B_Q_LAST: begin
        rem_d   = '0;
        dvd_d   = acc_d;
        cnt_d   = '0;
        state_d = B_DIV;
      end
      B_DIV: begin
        // Restoring division, one quotient bit per cycle
        for (int c = 0; c < CHANNELS; c++) begin
          rem_sh = {rem_q[c][REM_W-2:0], dvd_q[c][SUM_W-1]};
          if (rem_sh >= REM_W'(cmd_q.area)) begin
            rem_d[c] = rem_sh - REM_W'(cmd_q.area);
            dvd_d[c] = {dvd_q[c][SUM_W-2:0], 1'b1};
          end else begin
            rem_d[c] = rem_sh;
            dvd_d[c] = {dvd_q[c][SUM_W-2:0], 1'b0};
          end
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (32'(cnt_q) == SUM_W - 1) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_q || pop) begin
          out_load = 1'b1;
          for (int c = 0; c < OUT_CH; c++) begin
            out_d[c] = (c < CHANNELS) ? dvd_q[c % CHANNELS][PIX_W-1:0] : '0;
          end
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~pop);

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      k_q         <= '0;
      cnt_q       <= '0;
      run_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      pend_q      <= mem_re && (state_q == B_Q_RD);
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    rd_zero_q <= rd_zero_d;
    rd_neg_q  <= k_q[0] ^ k_q[1];
    acc_q     <= acc_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    out_q     <= out_d;
  end

  assign empty   = ~out_valid_q;
  assign mean0_o = out_q[0];
  assign mean1_o = out_q[1];
  assign mean2_o = out_q[2];
  assign mean3_o = out_q[3];

`ifndef SYNTHESIS
  a_area_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> cmd_q.area != '0)
    else $error("division started with zero window area");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop |=> out_valid_q && $stable(out_q))
    else $error("waiting result lost or changed");

  a_write_only_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !cmd_q.is_query && $past(state_q) == B_LD_RD)
    else $error("table written outside a load");
`endif

endmodule

>>> design/integral_image_box_filter_rgba.sv
// Top level of the integral image box filter for four-channel pixels.
// Loads (func 0) bring pixels in raster order and update a per-channel
// summed-area table in a 65536-entry memory; queries (func 1) return the four
// truncated channel means over the clipped window around the queried pixel.
// A front end tracks the load position and clips the window, a two-entry queue
// decouples it from the back end, which owns the single-port memory. In the back
// end a load is taken, reads the row above and then writes its entry; a query
// makes 4 corner reads through the one read port, then runs a restoring
// divider, one quotient bit per cycle for all channels at once. The result
// register frees the back end as soon as a result is handed to it.
module integral_image_box_filter_rgba
  import iibf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              push,
  output logic              full,
  input  logic              func_i,
  input  logic [PIX_W-1:0]  chan0_i,
  input  logic [PIX_W-1:0]  chan1_i,
  input  logic [PIX_W-1:0]  chan2_i,
  input  logic [PIX_W-1:0]  chan3_i,
  input  logic [QRY_W-1:0]  query_x_i,
  input  logic [QRY_W-1:0]  query_y_i,
  output logic              empty,
  input  logic              pop,
  output logic [PIX_W-1:0]  mean0_o,
  output logic [PIX_W-1:0]  mean1_o,
  output logic [PIX_W-1:0]  mean2_o,
  output logic [PIX_W-1:0]  mean3_o
);

  cmd_t front_cmd, back_cmd;
  logic accept, cmd_empty, cmd_pop;

  assign accept = push & ~full;

  iibf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .func_i      (func_i),
    .chan0_i     (chan0_i),
    .chan1_i     (chan1_i),
    .chan2_i     (chan2_i),
    .chan3_i     (chan3_i),
    .query_x_i   (query_x_i),
    .query_y_i   (query_y_i),
    .cmd_o       (front_cmd)
  );

  iibf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_cmd),
    .full_o  (full),
    .rd_i    (cmd_pop),
    .rdata_o (back_cmd),
    .empty_o (cmd_empty)
  );

  iibf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .mean0_o     (mean0_o),
    .mean1_o     (mean1_o),
    .mean2_o     (mean2_o),
    .mean3_o     (mean3_o)
  );

endmodule
